### design/id_pool_allocator_defines.svh
// assertion macros shared by the id pool allocator rtl
`ifndef ID_POOL_ALLOCATOR_DEFINES_SVH
`define ID_POOL_ALLOCATOR_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define IPA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define IPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ipa_pkg.sv
// types and constants of the id pool allocator
package ipa_pkg;

  // fixed field widths
  localparam int WIN_W    = 10;
  localparam int SID_W    = 20;
  localparam int TAG_IN_W = 16;
  localparam int FUNC_W   = 2;
  localparam int COUNT_W  = 11;

  // largest identifier a window register can name
  localparam logic [COUNT_W-1:0] WIN_MAX = 11'd1023;

  // parameter defaults
  localparam int DEF_MAP_ENTRIES = 1024;
  localparam int DEF_TAG_WIDTH   = 16;

  // reset values of the window registers
  localparam logic [WIN_W-1:0] WINDOW_LOW_RST  = 10'd1;
  localparam logic [WIN_W-1:0] WINDOW_HIGH_RST = 10'd1023;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_LOOKUP = 2'd3
  } func_t;

  typedef enum logic {
    CFG_WINDOW_LOW  = 1'b0,
    CFG_WINDOW_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

### design/ipa_table.sv
// entry table: valid mark and tag per identifier, one read and one write port
module ipa_table #(
  parameter int MAP_ENTRIES = ipa_pkg::DEF_MAP_ENTRIES,
  parameter int TAG_WIDTH   = ipa_pkg::DEF_TAG_WIDTH
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(MAP_ENTRIES)-1:0] rd_addr,
  output logic                           rd_valid,
  output logic [TAG_WIDTH-1:0]           rd_tag,
  input  logic                           wr_en,
  input  logic [$clog2(MAP_ENTRIES)-1:0] wr_addr,
  input  logic                           wr_valid,
  input  logic [TAG_WIDTH-1:0]           wr_tag
);

  logic [TAG_WIDTH:0] mem [MAP_ENTRIES];
  logic [TAG_WIDTH:0] rd_q;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_tag};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_valid = rd_q[TAG_WIDTH];
  assign rd_tag   = rd_q[TAG_WIDTH-1:0];

endmodule

### design/ipa_rem.sv
// bit-serial remainder of the probe cursor by the window size
module ipa_rem (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ipa_pkg::WIN_W-1:0] dividend,
  input  logic [ipa_pkg::WIN_W-1:0] divisor,
  output logic                     done,
  output logic [ipa_pkg::WIN_W-1:0] rem
);

  localparam int CNT_W = $clog2(ipa_pkg::WIN_W + 1);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [ipa_pkg::WIN_W-1:0] dq;
  logic [ipa_pkg::WIN_W-1:0] r;
  logic [ipa_pkg::WIN_W:0]   trial;

  // shift in the next dividend bit, subtract when it fits
  assign trial = {r, dq[ipa_pkg::WIN_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ipa_pkg::WIN_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      r  <= '0;
      dq <= dividend;
    end else if (busy) begin
      dq <= {dq[ipa_pkg::WIN_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        r <= ipa_pkg::WIN_W'(trial - {1'b0, divisor});
      end else begin
        r <= ipa_pkg::WIN_W'(trial);
      end
    end
  end

  assign rem = r;

endmodule

### design/id_pool_allocator.sv
// id pool allocator top level: control sequencer, window registers, result register
//
// Session identifier table of MAP_ENTRIES entries (valid mark plus tag) held in one
// single-port-read, single-port-write RAM with a registered read. After reset the
// block sweeps the RAM clear, one entry per cycle, and takes no item until the
// sweep ends; configuration writes are taken at any time. Insert, free and lookup
// pass from accept through the RAM read, the update and the result register to the
// result. Allocate fails without probing when the window is empty or its count is
// full; otherwise it probes the window one entry per cycle from the rotating cursor
// through the RAM read port until it claims a free entry or has probed the whole
// window; when a window change has left the cursor at or beyond the window size,
// the cursor is first reduced by a bit-serial remainder unit.
// One item is in work at a time; a new item is accepted while the previous result
// still waits in the output register.
`include "id_pool_allocator_defines.svh"

module id_pool_allocator #(
  parameter int MAP_ENTRIES = ipa_pkg::DEF_MAP_ENTRIES,
  parameter int TAG_WIDTH   = ipa_pkg::DEF_TAG_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ipa_pkg::FUNC_W-1:0]   func,
  input  logic [ipa_pkg::SID_W-1:0]    sid,
  input  logic [ipa_pkg::TAG_IN_W-1:0] user_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ipa_pkg::WIN_W-1:0]    sid_out,
  output logic                         ok,
  output logic [ipa_pkg::TAG_IN_W-1:0] user_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [ipa_pkg::WIN_W-1:0]    cfg_data
);

  localparam int          ADDR_W = $clog2(MAP_ENTRIES);
  localparam int unsigned MAX_ID = MAP_ENTRIES - 1;

  ipa_pkg::state_t state, state_next;

  // configuration and allocator state
  logic [ipa_pkg::WIN_W-1:0]   window_low, window_high;
  logic [ipa_pkg::COUNT_W-1:0] local_count;
  logic [ipa_pkg::WIN_W-1:0]   probe_cursor, probe_cursor_next;

  // latched item
  ipa_pkg::func_t              func_q;
  logic [ipa_pkg::SID_W-1:0]   sid_q;
  logic [ipa_pkg::TAG_IN_W-1:0] tag_q;

  // pending result
  logic [ipa_pkg::WIN_W-1:0]    res_sid;
  logic                         res_ok;
  logic [ipa_pkg::TAG_IN_W-1:0] res_user;

  // clear sweep and probe bookkeeping
  logic [ADDR_W-1:0]           clr_addr;
  logic [ipa_pkg::WIN_W-1:0]   iss_off, iss_off_next;
  logic [ipa_pkg::COUNT_W-1:0] iss_cnt;
  logic [ipa_pkg::WIN_W-1:0]   rd_off;
  logic                        rd_pend;

  // ram ports
  logic                 mem_rd_en;
  logic [ADDR_W-1:0]    mem_rd_addr;
  logic                 mem_rd_valid;
  logic [TAG_WIDTH-1:0] mem_rd_tag;
  logic                 mem_wr_en;
  logic [ADDR_W-1:0]    mem_wr_addr;
  logic                 mem_wr_valid;
  logic [TAG_WIDTH-1:0] mem_wr_tag;

  // remainder unit
  logic                      rem_start;
  logic                      rem_done;
  logic [ipa_pkg::WIN_W-1:0] rem_val;

  // derived window
  logic [ipa_pkg::WIN_W-1:0] lo, hi, win;
  logic                      win_ok;
  logic                      alloc_go;
  logic                      accept;
  logic                      in_range_q;
  logic                      in_win_q;
  logic                      issue;
  logic                      found;
  logic                      probe_fail;
  logic                      out_free;
  logic [ipa_pkg::WIN_W-1:0] found_sid;

  ipa_table #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_table (
    .clk      (clk),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_valid (mem_rd_valid),
    .rd_tag   (mem_rd_tag),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_valid (mem_wr_valid),
    .wr_tag   (mem_wr_tag)
  );

  ipa_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (probe_cursor),
    .divisor  (win),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // effective window bounds and size
  assign lo     = (window_low == '0) ? ipa_pkg::WIN_W'(1) : window_low;
  assign hi     = (32'(window_high) > MAX_ID) ? ipa_pkg::WIN_W'(MAX_ID) : window_high;
  assign win_ok = (hi >= lo);
  assign win    = ipa_pkg::WIN_W'(hi - lo + ipa_pkg::WIN_W'(1));

  // handshake helpers
  assign in_ready  = (state == ipa_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign alloc_go  = win_ok && (local_count < {1'b0, win});

  // checks on the latched identifier
  assign in_range_q = (sid_q != '0) && (32'(sid_q) < 32'(MAP_ENTRIES));
  assign in_win_q   = (sid_q >= ipa_pkg::SID_W'(lo)) && (sid_q <= ipa_pkg::SID_W'(hi));

  // probe pipeline status
  assign found      = (state == ipa_pkg::ST_PROBE) && rd_pend && !mem_rd_valid;
  assign probe_fail = (state == ipa_pkg::ST_PROBE) && !rd_pend && (iss_cnt == {1'b0, win});
  assign issue      = (state == ipa_pkg::ST_PROBE) && !found && (iss_cnt < {1'b0, win});
  assign found_sid  = lo + rd_off;

  // circular step of the probe offset and the next cursor
  assign iss_off_next      = (iss_off + ipa_pkg::WIN_W'(1) == win) ? '0
                             : iss_off + ipa_pkg::WIN_W'(1);
  assign probe_cursor_next = (rd_off + ipa_pkg::WIN_W'(1) == win) ? '0
                             : rd_off + ipa_pkg::WIN_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ipa_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_W'(MAX_ID)) state_next = ipa_pkg::ST_IDLE;
      end
      ipa_pkg::ST_IDLE: begin
        if (accept) begin
          if (ipa_pkg::func_t'(func) != ipa_pkg::FUNC_ALLOC) begin
            state_next = ipa_pkg::ST_READ;
          end else if (!alloc_go) begin
            state_next = ipa_pkg::ST_DONE;
          end else if (probe_cursor >= win) begin
            state_next = ipa_pkg::ST_MOD;
          end else begin
            state_next = ipa_pkg::ST_PROBE;
          end
        end
      end
      ipa_pkg::ST_READ: begin
        state_next = ipa_pkg::ST_DONE;
      end
      ipa_pkg::ST_MOD: begin
        if (rem_done) state_next = ipa_pkg::ST_PROBE;
      end
      ipa_pkg::ST_PROBE: begin
        if (found || probe_fail) state_next = ipa_pkg::ST_DONE;
      end
      ipa_pkg::ST_DONE: begin
        if (out_free) state_next = ipa_pkg::ST_IDLE;
      end
      default: state_next = ipa_pkg::ST_IDLE;
    endcase
  end

  // ram and remainder unit controls
  always_comb begin
    mem_rd_en    = 1'b0;
    mem_rd_addr  = ADDR_W'(sid);
    mem_wr_en    = 1'b0;
    mem_wr_addr  = ADDR_W'(sid_q);
    mem_wr_valid = 1'b0;
    mem_wr_tag   = '0;
    rem_start    = 1'b0;
    case (state)
      ipa_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
      end
      ipa_pkg::ST_IDLE: begin
        mem_rd_en = accept && (ipa_pkg::func_t'(func) != ipa_pkg::FUNC_ALLOC);
        rem_start = accept && (ipa_pkg::func_t'(func) == ipa_pkg::FUNC_ALLOC)
                    && alloc_go && (probe_cursor >= win);
      end
      ipa_pkg::ST_READ: begin
        if (in_range_q && (func_q == ipa_pkg::FUNC_INSERT) && !mem_rd_valid) begin
          mem_wr_en    = 1'b1;
          mem_wr_valid = 1'b1;
          mem_wr_tag   = TAG_WIDTH'(tag_q);
        end else if (in_range_q && (func_q == ipa_pkg::FUNC_FREE) && mem_rd_valid) begin
          mem_wr_en = 1'b1;
        end
      end
      ipa_pkg::ST_PROBE: begin
        mem_rd_en   = issue;
        mem_rd_addr = ADDR_W'(lo + iss_off);
        if (found) begin
          mem_wr_en    = 1'b1;
          mem_wr_addr  = ADDR_W'(found_sid);
          mem_wr_valid = 1'b1;
          mem_wr_tag   = TAG_WIDTH'(tag_q);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ipa_pkg::ST_CLEAR;
      clr_addr     <= '0;
      window_low   <= ipa_pkg::WINDOW_LOW_RST;
      window_high  <= ipa_pkg::WINDOW_HIGH_RST;
      local_count  <= '0;
      probe_cursor <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (state == ipa_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      // configuration beat
      if (cfg_valid) begin
        case (ipa_pkg::cfg_reg_t'(cfg_index))
          ipa_pkg::CFG_WINDOW_LOW:  window_low  <= cfg_data;
          ipa_pkg::CFG_WINDOW_HIGH: window_high <= cfg_data;
          default: begin
          end
        endcase
      end
      // occupancy count and cursor
      if (found) begin
        local_count  <= local_count + ipa_pkg::COUNT_W'(1);
        probe_cursor <= probe_cursor_next;
      end else if ((state == ipa_pkg::ST_READ) && (func_q == ipa_pkg::FUNC_FREE)
                   && in_range_q && mem_rd_valid && in_win_q && (local_count != '0)) begin
        local_count <= local_count - ipa_pkg::COUNT_W'(1);
      end
      // result register
      if ((state == ipa_pkg::ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= ipa_pkg::func_t'(func);
      sid_q    <= sid;
      tag_q    <= user_tag;
      res_sid  <= '0;
      res_ok   <= 1'b0;
      res_user <= '0;
    end
    if (state == ipa_pkg::ST_READ) begin
      case (func_q)
        ipa_pkg::FUNC_INSERT: res_ok <= in_range_q && !mem_rd_valid;
        ipa_pkg::FUNC_LOOKUP: begin
          res_ok   <= in_range_q && mem_rd_valid;
          res_user <= (in_range_q && mem_rd_valid) ? ipa_pkg::TAG_IN_W'(mem_rd_tag) : '0;
        end
        default: begin
        end
      endcase
    end
    if (rem_done && (state == ipa_pkg::ST_MOD)) begin
      iss_off <= rem_val;
      iss_cnt <= '0;
    end else if (accept) begin
      iss_off <= probe_cursor;
      iss_cnt <= '0;
    end else if (issue) begin
      iss_off <= iss_off_next;
      iss_cnt <= iss_cnt + ipa_pkg::COUNT_W'(1);
    end
    if (issue) begin
      rd_off <= iss_off;
    end
    if (found) begin
      res_sid <= found_sid;
      res_ok  <= 1'b1;
    end
    if ((state == ipa_pkg::ST_DONE) && out_free) begin
      sid_out  <= res_sid;
      ok       <= res_ok;
      user_out <= res_user;
    end
  end

  // checks
  `IPA_ASSERT_ALWAYS(a_count_bound, clk, rst, local_count <= ipa_pkg::WIN_MAX, "local count above window maximum")
  `IPA_ASSERT_IMPLY(a_found_in_window, clk, rst, found, rd_off < win, "claimed entry outside window")
  `IPA_ASSERT_NEXT(a_found_done, clk, rst, found, state == ipa_pkg::ST_DONE, "claim did not end the probe")

endmodule
